>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the sorted min priority queue
// Operation codes, word width and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [0:0] {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	// broadcast to all cells in the cycle an operation is taken
	typedef struct packed {
		logic  push;
		logic  pop;
		word_t value;
	} cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// Holds one word; on a push keeps it, takes the lower neighbour's word or
// takes the new word; on a pop takes the upper neighbour's word.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occ,      // slot holds a live entry
	input  logic               prev_le,  // lower slot is live and <= new word
	input  spq_pkg::word_t     prev_word,
	input  spq_pkg::word_t     next_word,
	output logic               le,
	output spq_pkg::word_t     word
);
	import spq_pkg::*;

	word_t word_q;

	// live and not greater than the incoming word: stays put on a push
	assign le   = occ && !(word_q > ctrl.value);
	assign word = word_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			word_q <= next_word;
		end else if (ctrl.push && !le) begin
			// insertion point is the first slot whose lower neighbour stays
			word_q <= prev_le ? ctrl.value : prev_word;
		end
	end

endmodule

>>> rtl/sorted_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core - shift-register minimum priority queue
// Row of DEPTH cells kept in ascending order, smallest at cell 0.
// ----------------------------------------------------------------------------
// Takes one word per cycle while item_ready is high: a push (func 0) inserts
// value after every stored entry not greater than it, so equal values leave
// in arrival order; a pop (func 1) removes the smallest entry and returns it
// on the result channel. Every cell compares against the broadcast value and
// shifts in the cycle the operation is taken, and the popped word is
// valid on the result register the cycle after acceptance. Pushes are taken
// even while a result waits; a pop is held off only while the result
// register is still full and not being drained. A pop on an empty queue is
// taken and gives no result; a push on a full queue is taken and dropped.
// No clearing pass is needed after reset: the entry count alone marks which
// cells are live.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// operation channel
	input  logic                item_valid,
	output logic                item_ready,
	input  spq_pkg::func_t      func,
	input  spq_pkg::word_t      value,
	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output spq_pkg::word_t      popped_value
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             result_valid_q;
	word_t            popped_value_q;

	logic        accept;
	logic        is_pop;
	logic        empty;
	logic        full;
	cell_ctrl_t  ctrl;

	logic        le   [DEPTH];
	word_t       word [DEPTH];

	assign is_pop = (func == FUNC_POP);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(DEPTH));

	// a pop needs the result register free (or emptying this cycle);
	// pushes and pops that produce nothing never wait
	assign item_ready = !result_valid_q || result_ready || !is_pop || empty;
	assign accept     = item_valid && item_ready;

	assign ctrl.push  = accept && !is_pop && !full;
	assign ctrl.pop   = accept &&  is_pop && !empty;
	assign ctrl.value = value;

	// the chain; cell 0 sees a virtual lower neighbour that always stays
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic  occ;
		logic  prev_le;
		word_t prev_word;
		word_t next_word;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_le   = 1'b1;
			assign prev_word = value;
		end else begin : g_mid
			assign prev_le   = le[i-1];
			assign prev_word = word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_word = word[i];
		end else begin : g_inner
			assign next_word = word[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ),
			.prev_le   (prev_le),
			.prev_word (prev_word),
			.next_word (next_word),
			.le        (le[i]),
			.word      (word[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// result register: popped word (smallest lives in cell 0)
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			popped_value_q <= word[0];
		end
	end

	assign result_valid = result_valid_q;
	assign popped_value = popped_value_q;

endmodule
